/* hdl/trgb_pkg.sv */
package trgb_pkg;

  typedef enum logic {
    OP_PIXEL,
    OP_PAD
  } op_t;

  typedef enum logic [1:0] {
    FMT_BGRA,
    FMT_RGBA,
    FMT_BGR,
    FMT_RGB
  } fmt_t;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_ALPHA  = 2'd2;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [17:0] CY_R = 18'sd19595;
  localparam logic signed [17:0] CY_G = 18'sd38470;
  localparam logic signed [17:0] CY_B = 18'sd7471;
  localparam logic signed [17:0] CU_R = -18'sd11071;
  localparam logic signed [17:0] CU_G = -18'sd21736;
  localparam logic signed [17:0] CU_B = 18'sd32807;
  localparam logic signed [17:0] CV_R = 18'sd32756;
  localparam logic signed [17:0] CV_G = -18'sd27429;
  localparam logic signed [17:0] CV_B = -18'sd5327;

  localparam logic signed [12:0] CHROMA_OFFSET = 13'sd128;
  localparam logic signed [12:0] BYTE_MAX      = 13'sd255;

  typedef struct packed {
    op_t        op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] v;
    logic [7:0] u;
    logic [7:0] y;
  } pixel_t;

endpackage

/* hdl/trgb_ram.sv */
module trgb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/trgb_front.sv */
module trgb_front #(
  parameter int TILE_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  input  logic              pix_valid,
  input  logic              req_type,
  input  logic [7:0]        first_byte,
  input  logic [7:0]        second_byte,
  input  logic [7:0]        third_byte,
  input  logic [7:0]        fourth_byte,
  input  logic              full,
  output logic              push,
  output trgb_pkg::item_t   item,
  output logic [6:0]        row_width
);

  trgb_pkg::fmt_t fmt;
  logic [6:0]     width;
  logic           alpha_en;
  logic           four;
  logic           bgr;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt      <= trgb_pkg::FMT_BGRA;
      width    <= 7'd64;
      alpha_en <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        trgb_pkg::REG_FORMAT: fmt      <= trgb_pkg::fmt_t'(cfg_data[1:0]);
        trgb_pkg::REG_WIDTH:  width    <= cfg_data;
        trgb_pkg::REG_ALPHA:  alpha_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    four = (fmt == trgb_pkg::FMT_BGRA) || (fmt == trgb_pkg::FMT_RGBA);
    bgr  = (fmt == trgb_pkg::FMT_BGRA) || (fmt == trgb_pkg::FMT_BGR);
    item.op = req_type ? trgb_pkg::OP_PAD : trgb_pkg::OP_PIXEL;
    item.g  = second_byte;
    if (bgr) begin
      item.b = first_byte;
      item.r = third_byte;
    end else begin
      item.r = first_byte;
      item.b = third_byte;
    end
    item.a = (four && alpha_en) ? fourth_byte : 8'd0;
    if (width == 7'd0) begin
      row_width = 7'd1;
    end else if (width > 7'(TILE_SIZE)) begin
      row_width = 7'(TILE_SIZE);
    end else begin
      row_width = width;
    end
  end

  assign push = pix_valid && !full;

endmodule

/* hdl/trgb_queue.sv */
module trgb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  trgb_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output trgb_pkg::item_t head_item
);

  localparam int PW = (trgb_pkg::QUEUE_DEPTH > 1) ? $clog2(trgb_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(trgb_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(trgb_pkg::QUEUE_DEPTH - 1);

  trgb_pkg::item_t entries [trgb_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full       = (count == CW'(trgb_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_item;
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/trgb_back.sv */
module trgb_back #(
  parameter int TILE_SIZE = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  trgb_pkg::item_t q_item,
  output logic            q_pop,
  input  logic [6:0]      row_width,
  output logic            res_valid,
  input  logic            res_stall,
  output logic [7:0]      luma,
  output logic [7:0]      blue_difference,
  output logic [7:0]      red_difference,
  output logic [7:0]      alpha,
  output logic            last_of_run,
  output logic            tile_end
);

  localparam int CW = $clog2(TILE_SIZE);
  localparam logic [CW-1:0] LAST_COL = CW'(TILE_SIZE - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_RUN,
    S_PAD
  } state_t;

  state_t                  state;
  logic [CW-1:0]           col;
  logic [CW-1:0]           row;
  logic [CW-1:0]           run_idx;
  logic                    single;
  logic                    run_tend;
  trgb_pkg::pixel_t        px;
  logic [7:0]              a_hold;
  logic signed [26:0]      prod [9];

  logic                    slot_free;
  logic [CW-1:0]           raddr;
  trgb_pkg::pixel_t        rdata;
  logic                    we;
  logic signed [28:0]      sum_y;
  logic signed [28:0]      sum_u;
  logic signed [28:0]      sum_v;
  logic signed [12:0]      ys;
  logic signed [12:0]      us;
  logic signed [12:0]      vs;
  logic                    row_end;
  logic [6:0]              row_inc;
  logic                    row_wrap;
  logic                    run_last;

  function automatic logic signed [26:0] mul(input logic [7:0] x,
                                             input logic signed [17:0] c);
    return $signed({19'd0, x}) * c;
  endfunction

  function automatic logic [7:0] clamp(input logic signed [12:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > trgb_pkg::BYTE_MAX) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  assign slot_free = !res_valid || !res_stall;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign we        = (state == S_RUN) && slot_free;
  assign run_last  = (run_idx == LAST_COL);

  always_comb begin
    if (state == S_IDLE) begin
      raddr = '0;
    end else if (state == S_PAD && slot_free && !run_last) begin
      raddr = run_idx + 1'b1;
    end else begin
      raddr = run_idx;
    end
  end

  always_comb begin
    sum_y = 29'(prod[0]) + 29'(prod[1]) + 29'(prod[2]);
    sum_u = 29'(prod[3]) + 29'(prod[4]) + 29'(prod[5]);
    sum_v = 29'(prod[6]) + 29'(prod[7]) + 29'(prod[8]);
    ys = 13'(sum_y >>> 16);
    us = 13'(sum_u >>> 16) + trgb_pkg::CHROMA_OFFSET;
    vs = 13'(sum_v >>> 16) + trgb_pkg::CHROMA_OFFSET;
    row_end  = (7'(col) + 7'd1) >= row_width;
    row_inc  = 7'(row) + 7'd1;
    row_wrap = row_inc >= 7'(TILE_SIZE);
  end

  trgb_ram #(
    .WIDTH(32),
    .DEPTH(TILE_SIZE)
  ) u_row_store (
    .clk  (clk),
    .we   (we),
    .waddr(run_idx),
    .wdata(px),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      col       <= '0;
      row       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        res_valid <= (state == S_RUN) || (state == S_PAD);
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.op == trgb_pkg::OP_PIXEL) begin
              prod[0] <= mul(q_item.r, trgb_pkg::CY_R);
              prod[1] <= mul(q_item.g, trgb_pkg::CY_G);
              prod[2] <= mul(q_item.b, trgb_pkg::CY_B);
              prod[3] <= mul(q_item.r, trgb_pkg::CU_R);
              prod[4] <= mul(q_item.g, trgb_pkg::CU_G);
              prod[5] <= mul(q_item.b, trgb_pkg::CU_B);
              prod[6] <= mul(q_item.r, trgb_pkg::CV_R);
              prod[7] <= mul(q_item.g, trgb_pkg::CV_G);
              prod[8] <= mul(q_item.b, trgb_pkg::CV_B);
              a_hold  <= q_item.a;
              state   <= S_CONV;
            end else if (col == '0) begin
              row      <= row_wrap ? '0 : CW'(row_inc);
              run_tend <= row_wrap;
              run_idx  <= '0;
              state    <= S_PAD;
            end
          end
        end
        S_CONV: begin
          px.y    <= clamp(ys);
          px.u    <= clamp(us);
          px.v    <= clamp(vs);
          px.a    <= a_hold;
          run_idx <= col;
          if (row_end) begin
            single   <= 1'b0;
            col      <= '0;
            row      <= row_wrap ? '0 : CW'(row_inc);
            run_tend <= row_wrap;
          end else begin
            single <= 1'b1;
            col    <= col + 1'b1;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (slot_free) begin
            luma            <= px.y;
            blue_difference <= px.u;
            red_difference  <= px.v;
            alpha           <= px.a;
            last_of_run     <= single || run_last;
            tile_end        <= !single && run_last && run_tend;
            if (single || run_last) begin
              state <= S_IDLE;
            end else begin
              run_idx <= run_idx + 1'b1;
            end
          end
        end
        S_PAD: begin
          if (slot_free) begin
            luma            <= rdata.y;
            blue_difference <= rdata.u;
            red_difference  <= rdata.v;
            alpha           <= rdata.a;
            last_of_run     <= run_last;
            tile_end        <= run_last && run_tend;
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              run_idx <= run_idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/tile_rgb_to_yuv_pad_top.sv */
// Converts one source pixel per item into clamped YUV with optional alpha and pads each tile
// row out to TILE_SIZE columns by repeating its last pixel; a pad-row item replays the stored
// last row, and one that arrives mid-row is dropped. Items enter a two-deep queue at up to one
// per cycle unless the queue is full, and the back-end sequencer works on one item at a time:
// a pixel is converted and then sent, a pixel that ends a row is repeated to the last column,
// a pad row is read out of the row store, a dropped pad row is only popped, and any stall on
// the result side holds the sequencer. Runs deliver one result per cycle from the held pixel,
// and pad rows one result per cycle from the row store, while the result side does not stall.
module tile_rgb_to_yuv_pad_top #(
  parameter int TILE_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  logic       pix_valid,
  output logic       pix_stall,
  input  logic       req_type,
  input  logic [7:0] first_byte,
  input  logic [7:0] second_byte,
  input  logic [7:0] third_byte,
  input  logic [7:0] fourth_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] luma,
  output logic [7:0] blue_difference,
  output logic [7:0] red_difference,
  output logic [7:0] alpha,
  output logic       last_of_run,
  output logic       tile_end
);

  logic            full;
  logic            push;
  trgb_pkg::item_t push_item;
  logic [6:0]      row_width;
  logic            pop;
  logic            head_valid;
  trgb_pkg::item_t head_item;

  assign pix_stall = full;

  trgb_front #(
    .TILE_SIZE(TILE_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .req_type   (req_type),
    .first_byte (first_byte),
    .second_byte(second_byte),
    .third_byte (third_byte),
    .fourth_byte(fourth_byte),
    .full       (full),
    .push       (push),
    .item       (push_item),
    .row_width  (row_width)
  );

  trgb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  trgb_back #(
    .TILE_SIZE(TILE_SIZE)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (head_valid),
    .q_item         (head_item),
    .q_pop          (pop),
    .row_width      (row_width),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .luma           (luma),
    .blue_difference(blue_difference),
    .red_difference (red_difference),
    .alpha          (alpha),
    .last_of_run    (last_of_run),
    .tile_end       (tile_end)
  );

endmodule

/* hdl/trgb_checker.sv */
module trgb_checker (
  input logic       clk,
  input logic       rst,
  input logic       pix_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] luma,
  input logic [7:0] blue_difference,
  input logic [7:0] red_difference,
  input logic [7:0] alpha,
  input logic       last_of_run,
  input logic       tile_end
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("Result valid right after reset.");

  a_reset_accepts: assert property (@(posedge clk) rst |=> !pix_stall)
    else $error("Input stalled right after reset.");

  a_tile_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && tile_end |-> last_of_run)
    else $error("Tile end flagged on a result that is not last of its run.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(luma) && $stable(blue_difference) &&
      $stable(red_difference) && $stable(alpha) && $stable(last_of_run) &&
      $stable(tile_end))
    else $error("Stalled result changed.");

endmodule

bind tile_rgb_to_yuv_pad_top trgb_checker u_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int TILE = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 56;
  localparam int RANDOM_PHASES = 8;

  typedef struct packed {
    trgb_pkg::pixel_t px;
    logic             last;
    logic             tend;
  } yuv_result_t;

  class yuv_tile_scoreboard #(int TILE = 64);
    trgb_pkg::fmt_t   fmt;
    logic [6:0]       width_reg;
    logic             alpha_on;
    int               column;
    int               rows;
    trgb_pkg::pixel_t last_px;
    trgb_pkg::pixel_t row_mem[TILE];
    bit               any_row_done;
    yuv_result_t      pending_results[$];
    int               errors;
    int               results_seen;
    int               pixels_in;
    int               pad_rows;
    int               dropped;
    int               tiles;

    function new();
      fmt = trgb_pkg::FMT_BGRA;
      width_reg = 7'd64;
      alpha_on = 1'b0;
      column = 0;
      rows = 0;
      last_px = '0;
      foreach (row_mem[i]) row_mem[i] = '0;
      any_row_done = 0;
      errors = 0;
      results_seen = 0;
      pixels_in = 0;
      pad_rows = 0;
      dropped = 0;
      tiles = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] data);
      case (idx)
        trgb_pkg::REG_FORMAT: fmt = trgb_pkg::fmt_t'(data[1:0]);
        trgb_pkg::REG_WIDTH:  width_reg = data;
        trgb_pkg::REG_ALPHA:  alpha_on = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp_byte(int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return x[7:0];
    endfunction

    function trgb_pkg::pixel_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic [7:0] a);
      int rs, gs, bs;
      trgb_pkg::pixel_t px;
      rs = r;
      gs = g;
      bs = b;
      px.y = clamp_byte((rs * trgb_pkg::CY_R + gs * trgb_pkg::CY_G + bs * trgb_pkg::CY_B)
                        >>> 16);
      px.u = clamp_byte(((rs * trgb_pkg::CU_R + gs * trgb_pkg::CU_G + bs * trgb_pkg::CU_B)
                         >>> 16) + trgb_pkg::CHROMA_OFFSET);
      px.v = clamp_byte(((rs * trgb_pkg::CV_R + gs * trgb_pkg::CV_G + bs * trgb_pkg::CV_B)
                         >>> 16) + trgb_pkg::CHROMA_OFFSET);
      px.a = a;
      return px;
    endfunction

    function void end_row(output logic tend);
      rows++;
      tend = rows >= TILE;
      if (tend) begin
        rows = 0;
        tiles++;
      end
    endfunction

    function void note_item(trgb_pkg::op_t op, logic [7:0] b0, logic [7:0] b1,
                            logic [7:0] b2, logic [7:0] b3);
      trgb_pkg::pixel_t px;
      int w;
      logic tend;
      logic [7:0] r, g, b, a;
      if (op == trgb_pkg::OP_PAD) begin
        if (column != 0) begin
          dropped++;
          return;
        end
        pad_rows++;
        end_row(tend);
        for (int i = 0; i < TILE; i++)
          pending_results.push_back('{row_mem[i], i == TILE - 1, (i == TILE - 1) && tend});
        return;
      end
      pixels_in++;
      if (fmt == trgb_pkg::FMT_BGRA || fmt == trgb_pkg::FMT_BGR) begin
        r = b2; g = b1; b = b0;
      end else begin
        r = b0; g = b1; b = b2;
      end
      a = ((fmt == trgb_pkg::FMT_BGRA || fmt == trgb_pkg::FMT_RGBA) && alpha_on) ? b3 : 8'h00;
      px = convert_pixel(r, g, b, a);
      last_px = px;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > TILE) w = TILE;
      row_mem[column] = px;
      if (column + 1 < w) begin
        column++;
        pending_results.push_back('{px, 1'b1, 1'b0});
        return;
      end
      end_row(tend);
      for (int i = column; i < TILE; i++) begin
        row_mem[i] = last_px;
        pending_results.push_back('{last_px, i == TILE - 1, (i == TILE - 1) && tend});
      end
      column = 0;
      any_row_done = 1;
    endfunction

    function void check_result(yuv_result_t got);
      yuv_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result y=%0d u=%0d v=%0d a=%0d last=%0b tend=%0b",
                   $time, got.px.y, got.px.u, got.px.v, got.px.a, got.last, got.tend);
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      if (got.px.y !== want.px.y || got.px.u !== want.px.u || got.px.v !== want.px.v ||
          got.px.a !== want.px.a || got.last !== want.last || got.tend !== want.tend) begin
        errors++;
        if (errors <= 10)
          $display("%0t: expected y=%0d u=%0d v=%0d a=%0d last=%0b tend=%0b,",
                   $time, want.px.y, want.px.u, want.px.v, want.px.a, want.last, want.tend,
                   " got y=%0d u=%0d v=%0d a=%0d last=%0b tend=%0b",
                   got.px.y, got.px.u, got.px.v, got.px.a, got.last, got.tend);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = trgb_pkg::REG_FORMAT;
  logic [6:0] cfg_data = '0;
  logic       pix_valid = 1'b0;
  logic       pix_stall;
  logic       req_type = trgb_pkg::OP_PIXEL;
  logic [7:0] first_byte = '0;
  logic [7:0] second_byte = '0;
  logic [7:0] third_byte = '0;
  logic [7:0] fourth_byte = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] luma;
  logic [7:0] blue_difference;
  logic [7:0] red_difference;
  logic [7:0] alpha;
  logic       last_of_run;
  logic       tile_end;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int settings_used = 0;

  yuv_tile_scoreboard #(TILE) sb;

  tile_rgb_to_yuv_pad_top #(.TILE_SIZE(TILE)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .req_type(req_type),
    .first_byte(first_byte),
    .second_byte(second_byte),
    .third_byte(third_byte),
    .fourth_byte(fourth_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .luma(luma),
    .blue_difference(blue_difference),
    .red_difference(red_difference),
    .alpha(alpha),
    .last_of_run(last_of_run),
    .tile_end(tile_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write)
        sb.write_reg(cfg_index, cfg_data);
      if (pix_valid && !pix_stall)
        sb.note_item(trgb_pkg::op_t'(req_type), first_byte, second_byte, third_byte,
                     fourth_byte);
      if (res_valid && !res_stall)
        sb.check_result(yuv_result_t'({alpha, red_difference, blue_difference, luma,
                                       last_of_run, tile_end}));
    end
  end

  task automatic send_item(trgb_pkg::op_t op, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                           logic [7:0] b3);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    req_type <= op;
    first_byte <= b0;
    second_byte <= b1;
    third_byte <= b2;
    fourth_byte <= b3;
    do @(posedge clk); while (pix_stall);
  endtask

  task automatic set_config(trgb_pkg::fmt_t fmt, logic [6:0] width, logic alpha_on);
    cfg_write <= 1'b1;
    cfg_index <= trgb_pkg::REG_FORMAT;
    cfg_data <= 7'(fmt);
    @(posedge clk);
    cfg_index <= trgb_pkg::REG_WIDTH;
    cfg_data <= width;
    @(posedge clk);
    cfg_index <= trgb_pkg::REG_ALPHA;
    cfg_data <= 7'(alpha_on);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int goal;
    logic [6:0] w;
    trgb_pkg::op_t op;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 14;
    stall_pct = 14;
    set_config(trgb_pkg::FMT_BGRA, 7'd4, 1'b1);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(trgb_pkg::OP_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'h80);
    send_item(trgb_pkg::OP_PIXEL, 8'hff, 8'h00, 8'h00, 8'h01);
    send_item(trgb_pkg::OP_PAD, 8'h5a, 8'ha5, 8'hff, 8'h00);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h00, 8'h07);
    // A pad row in the middle of a row is dropped.
    send_item(trgb_pkg::OP_PAD, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(trgb_pkg::OP_PIXEL, 8'hff, 8'hff, 8'h00, 8'hff);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'hff, 8'hff, 8'h55);
    send_item(trgb_pkg::OP_PIXEL, 8'h12, 8'h34, 8'h56, 8'h78);
    drain();

    set_config(trgb_pkg::FMT_RGBA, 7'd1, 1'b1);
    send_item(trgb_pkg::OP_PIXEL, 8'hff, 8'h00, 8'h00, 8'hc8);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'h00, 8'hff, 8'h00);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h00, 8'hff);
    drain();

    set_config(trgb_pkg::FMT_BGR, 7'd0, 1'b1);
    send_item(trgb_pkg::OP_PIXEL, 8'hff, 8'h00, 8'h80, 8'hff);
    send_item(trgb_pkg::OP_PIXEL, 8'h01, 8'hfe, 8'h7f, 8'hff);
    send_item(trgb_pkg::OP_PAD, 8'h00, 8'h00, 8'h00, 8'h00);
    drain();

    set_config(trgb_pkg::FMT_RGB, 7'd127, 1'b0);
    send_item(trgb_pkg::OP_PIXEL, 8'h80, 8'h80, 8'h80, 8'hff);
    send_item(trgb_pkg::OP_PIXEL, 8'hff, 8'h80, 8'h00, 8'hff);
    send_item(trgb_pkg::OP_PIXEL, 8'h00, 8'h80, 8'hff, 8'hff);
    drain();

    // Narrowing the row below the current column ends it on the next pixel.
    set_config(trgb_pkg::FMT_RGB, 7'd2, 1'b1);
    send_item(trgb_pkg::OP_PIXEL, 8'h40, 8'hc0, 8'h20, 8'hee);
    send_item(trgb_pkg::OP_PAD, 8'hff, 8'h00, 8'hff, 8'h00);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      case (p)
        0: w = 7'd1;
        1: w = 7'd64;
        2: w = 7'd0;
        3: w = 7'd127;
        6: w = 7'($urandom_range(127));
        default: w = 7'($urandom_range(1, 8));
      endcase
      set_config(trgb_pkg::fmt_t'($urandom_range(3)), w, 1'($urandom_range(1)));
      if (p == 4) hold_requests++;
      goal = sb.pixels_in + sb.pad_rows + PHASE_ITEMS;
      while (sb.pixels_in + sb.pad_rows < goal) begin
        op = trgb_pkg::OP_PIXEL;
        if (sb.any_row_done) begin
          if (sb.column == 0 && $urandom_range(99) < 25) op = trgb_pkg::OP_PAD;
          else if ($urandom_range(99) < 4) op = trgb_pkg::OP_PAD;
        end
        send_item(op, pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
      drain();
    end

    $display("Checked %0d results from %0d pixels and %0d pad rows, %0d dropped mid-row.",
             sb.results_seen, sb.pixels_in, sb.pad_rows, sb.dropped);
    $display("Completed %0d tiles over %0d register settings with idle and stall phases.",
             sb.tiles, settings_used);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/trgb_pkg.sv
hdl/trgb_ram.sv
hdl/trgb_front.sv
hdl/trgb_queue.sv
hdl/trgb_back.sv
hdl/tile_rgb_to_yuv_pad_top.sv
hdl/trgb_checker.sv
dv/tb.sv
